// ===== sv/mpas_pkg.sv =====
// Shared mode codes and controller-to-datapath command type.
package mpas_pkg;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MOD = 2'd2;

  typedef struct packed {
    logic arith;
    logic sub;
    logic mod_wr;
    logic mod_end;
    logic rd_en;
    logic rd_last;
  } cmd_t;

endpackage

// ===== sv/multiprecision_add_sub_modadd.sv =====
// Add/subtract: each limb result strobes in the cycle after its beat is taken.
// Modular add: busy_o is high from the cycle after the final limb beat until the last
// stored word is read; each stored word strobes after the RAM read and done registers.
// Throughput: one limb beat per cycle while busy_o is low, set by the single-word
// adder chain; busy_o holds off new beats during a drain. Results are never stalled.
// Reset (rst_ni low, async) clears carry, borrow, word count and controller state.
module multiprecision_add_sub_modadd
  import mpas_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned MAX_WORDS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] a_word_i,
  input  logic [31:0] b_word_i,
  input  logic [31:0] modulus_word_i,
  input  logic        last_in_i,
  output logic        done_o,
  output logic [31:0] result_word_o,
  output logic        carry_out_o,
  output logic        last_out_o
);

  localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  cmd_t          cmd;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] count;

  mpas_ctrl #(
    .MAX_WORDS (MAX_WORDS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .mode_i    (mode_i),
    .last_in_i (last_in_i),
    .count_i   (count),
    .busy_o    (busy_o),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr)
  );

  mpas_dp #(
    .WORD_BITS (WORD_BITS),
    .MAX_WORDS (MAX_WORDS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_addr_i      (rd_addr),
    .a_word_i       (a_word_i),
    .b_word_i       (b_word_i),
    .modulus_word_i (modulus_word_i),
    .last_in_i      (last_in_i),
    .count_o        (count),
    .done_o         (done_o),
    .result_word_o  (result_word_o),
    .carry_out_o    (carry_out_o),
    .last_out_o     (last_out_o)
  );

endmodule

// ===== sv/mpas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mpas_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mpas_ctrl.sv =====
// Controller: accepts beats, sequences the modular drain of stored words.
module mpas_ctrl
  import mpas_pkg::*;
#(
  parameter int unsigned MAX_WORDS = 8,
  parameter int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    mode_i,
  input  logic          last_in_i,
  input  logic [AW-1:0] count_i,
  output logic          busy_o,
  output cmd_t          cmd_o,
  output logic [AW-1:0] rd_addr_o
);

  localparam logic IDLE  = 1'b0;
  localparam logic DRAIN = 1'b1;

  logic          state_q, state_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [AW-1:0] end_q, end_d;
  logic          accept;
  logic          run_end;

  assign accept  = start_i && (state_q == IDLE);
  assign run_end = last_in_i || (count_i == AW'(MAX_WORDS - 1));

  always_comb begin
    state_d = state_q;
    rd_d    = rd_q;
    end_d   = end_q;
    cmd_o   = '0;
    case (state_q)
      IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_ADD, MODE_SUB: begin
              cmd_o.arith = 1'b1;
              cmd_o.sub   = (mode_i == MODE_SUB);
            end
            MODE_MOD: begin
              cmd_o.mod_wr  = 1'b1;
              cmd_o.mod_end = run_end;
              if (run_end) begin
                state_d = DRAIN;
                rd_d    = '0;
                end_d   = count_i;
              end
            end
            default: ;
          endcase
        end
      end
      DRAIN: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_last = (rd_q == end_q);
        rd_d          = rd_q + AW'(1);
        if (rd_q == end_q) begin
          state_d = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      rd_q    <= '0;
      end_q   <= '0;
    end else begin
      state_q <= state_d;
      rd_q    <= rd_d;
      end_q   <= end_d;
    end
  end

  assign busy_o    = (state_q == DRAIN);
  assign rd_addr_o = rd_q;

`ifndef SYNTHESIS
  a_no_beat_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !(cmd_o.arith || cmd_o.mod_wr))
    else $error("beat taken while draining");
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DRAIN) |-> (rd_q <= end_q))
    else $error("drain address past run end");
  a_drain_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_last |=> (state_q == IDLE))
    else $error("drain did not finish");
  a_drain_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mod_end |=> (state_q == DRAIN) && (rd_q == '0))
    else $error("modular run end did not start drain");
`endif

endmodule

// ===== sv/mpas_dp.sv =====
// Datapath: word adder/subtractor, carry chain, word store and result registers.
module mpas_dp
  import mpas_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned MAX_WORDS = 8,
  parameter int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic [31:0]   a_word_i,
  input  logic [31:0]   b_word_i,
  input  logic [31:0]   modulus_word_i,
  input  logic          last_in_i,
  output logic [AW-1:0] count_o,
  output logic          done_o,
  output logic [31:0]   result_word_o,
  output logic          carry_out_o,
  output logic          last_out_o
);

  localparam int unsigned WB = WORD_BITS;

  logic [95:0]       a_ext, b_ext, p_ext;
  logic [WB-1:0]     a_w, b_w, p_w;
  logic [WB:0]       sum, diff, red;
  logic              use_red;
  logic [2*WB-1:0]   rdata;
  logic [WB-1:0]     out_w;
  logic [WB+31:0]    out_ext;

  logic              carry_q, carry_d;
  logic              rborrow_q, rborrow_d;
  logic [AW-1:0]     count_q, count_d;
  logic              use_red_q;
  logic              done_q, src_ram_q, last_q, cout_q;
  logic [WB-1:0]     word_q;

  assign a_ext = {64'd0, a_word_i};
  assign b_ext = {64'd0, b_word_i};
  assign p_ext = {64'd0, modulus_word_i};
  assign a_w   = a_ext[WB-1:0];
  assign b_w   = b_ext[WB-1:0];
  assign p_w   = p_ext[WB-1:0];

  assign sum     = {1'b0, a_w} + {1'b0, b_w} + (WB+1)'(carry_q);
  assign diff    = {1'b0, a_w} - {1'b0, b_w} - (WB+1)'(carry_q);
  assign red     = {1'b0, sum[WB-1:0]} - {1'b0, p_w} - (WB+1)'(rborrow_q);
  assign use_red = sum[WB] || !red[WB];

  always_comb begin
    carry_d   = carry_q;
    rborrow_d = rborrow_q;
    count_d   = count_q;
    if (cmd_i.arith) begin
      carry_d = last_in_i ? 1'b0 : (cmd_i.sub ? diff[WB] : sum[WB]);
    end else if (cmd_i.mod_wr) begin
      carry_d   = cmd_i.mod_end ? 1'b0 : sum[WB];
      rborrow_d = cmd_i.mod_end ? 1'b0 : red[WB];
      count_d   = cmd_i.mod_end ? '0 : count_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q   <= 1'b0;
      rborrow_q <= 1'b0;
      count_q   <= '0;
      done_q    <= 1'b0;
      src_ram_q <= 1'b0;
      last_q    <= 1'b0;
      cout_q    <= 1'b0;
      use_red_q <= 1'b0;
    end else begin
      carry_q   <= carry_d;
      rborrow_q <= rborrow_d;
      count_q   <= count_d;
      done_q    <= cmd_i.arith || cmd_i.rd_en;
      src_ram_q <= cmd_i.rd_en;
      last_q    <= cmd_i.arith ? last_in_i : cmd_i.rd_last;
      cout_q    <= cmd_i.arith && last_in_i && (cmd_i.sub ? diff[WB] : sum[WB]);
      if (cmd_i.mod_end) begin
        use_red_q <= use_red;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.arith) begin
      word_q <= cmd_i.sub ? diff[WB-1:0] : sum[WB-1:0];
    end
  end

  mpas_ram #(
    .WIDTH (2 * WB),
    .DEPTH (MAX_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mod_wr),
    .waddr_i (count_q),
    .wdata_i ({red[WB-1:0], sum[WB-1:0]}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  assign out_w   = src_ram_q ? (use_red_q ? rdata[2*WB-1:WB] : rdata[WB-1:0]) : word_q;
  assign out_ext = {32'd0, out_w};

  assign count_o       = count_q;
  assign done_o        = done_q;
  assign result_word_o = out_ext[31:0];
  assign carry_out_o   = cout_q;
  assign last_out_o    = last_q;

endmodule
